// ===== design/sbl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbl_pkg
// shared types, constants and helper functions of the scanline / blur block
// ---------------------------------------------------------------------------
package sbl_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int PIX_W      = 24;
    localparam int FW_W       = 10;
    localparam int FH_W       = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int LINE_W     = 2 * PIX_W;

    localparam logic [FW_W-1:0] FW_RESET = 10'd320;
    localparam logic [FH_W-1:0] FH_RESET = 9'd224;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCANLINE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUR         = 2'd3;

    localparam logic [7:0] SCAN_BASE = 8'd217;
    localparam logic [7:0] LUM_GAIN  = 8'd38;

    typedef enum logic {
        ALU_MUL,
        ALU_TAP
    } alu_op_t;

    typedef struct packed {
        logic             en;
        alu_op_t          op;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] c;
    } alu_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LUM,
        ST_FAC,
        ST_MUL,
        ST_DISPATCH,
        ST_NEMIT,
        ST_HTAP,
        ST_VLOAD,
        ST_VTAP,
        ST_VEMIT
    } state_t;

    // r/4 + g/2 + g/8 + b/8, at most 252
    function automatic logic [7:0] scan_lum(input logic [PIX_W-1:0] p);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = p[23:16];
        g = p[15:8];
        b = p[7:0];
        return {2'b00, r[7:2]} + {1'b0, g[7:1]} + {3'b000, g[7:3]} + {3'b000, b[7:3]};
    endfunction

    // 217 + v/255, v below 9577; divide by 255 as (v + 1 + v/256) / 256
    function automatic logic [7:0] scan_factor(input logic [13:0] v);
        logic [14:0] t;
        logic [5:0]  q;
        t = {1'b0, v} + 15'd1 + {9'd0, v[13:8]};
        q = t[13:8];
        return SCAN_BASE + {2'b00, q};
    endfunction

endpackage

// ===== design/scanline_and_separable_blur.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scanline_and_separable_blur
// raster pixel stream: odd-row scanline darkening, then 3x3 binomial blur
// ---------------------------------------------------------------------------
// pixels enter in raster order on in_valid / in_stall; the block counts column
// and row itself against frame_width / frame_height (to be written by the user
// on the cfg port only while idle; the block does not enforce it). each input
// beat gives zero to four output beats on out_valid / out_stall, carrying
// column, row, colour, last_of_run and frame_end. with blur on, results lag
// one pixel and one row, with extra beats at row ends and on the last row.
// a pixel passes the luma, factor and multiply states on odd rows with
// scanlines on, then dispatch and a direct emit, or with blur the tap, line
// load, vertical tap and emit states; at most one alu op per cycle.
// each line store access is one ram read plus one write.
// in_stall is high whenever a pixel is in work. the output register lets
// the next pixel enter while the last result still waits; a stalled
// receiver holds the sequencer at its next result.
// reset clears counts, config (320 x 224, both stages off) and the output;
// the line stores need no clearing, row 0 writes them before any read is used.
// ---------------------------------------------------------------------------
module scanline_and_separable_blur
    import sbl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COL_W-1:0]      out_x,
    output logic [ROW_W-1:0]      out_y,
    output logic [PIX_W-1:0]      out_pixel,
    output logic                  last_of_run,
    output logic                  frame_end,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg;
    state_t state_next;

    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic            scan_reg;
    logic            blur_reg;

    logic [COL_W-1:0] col_cnt_reg;
    logic [ROW_W-1:0] row_cnt_reg;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic             cur_row_end;
    logic             cur_last_row;
    logic             in_accept;

    logic [PIX_W-1:0] pix_reg;
    logic [COL_W-1:0] x_reg;
    logic [ROW_W-1:0] y_reg;
    logic             row_end_reg;
    logic             last_row_reg;
    logic             blur_item_reg;
    logic [1:0]       step_reg;
    logic [7:0]       f_reg;
    logic             phase_b_reg;
    logic             vsel_reg;
    logic [COL_W-1:0] col_reg;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] center_reg;
    logic [PIX_W-1:0] u_reg;
    logic [PIX_W-1:0] m_reg;
    logic [PIX_W-1:0] hv_reg;
    logic [PIX_W-1:0] up2;
    logic [7:0]       mul_byte;

    alu_req_t         alu_req;
    logic [PIX_W-1:0] alu_res;

    logic              ram_wr_en;
    logic [LINE_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [COL_W-1:0]  ram_rd_addr;
    logic [LINE_W-1:0] ram_rd_data;

    logic             out_free;
    logic             out_load;
    logic             out_valid_reg;
    logic [COL_W-1:0] out_x_reg;
    logic [COL_W-1:0] out_x_next;
    logic [ROW_W-1:0] out_y_reg;
    logic [ROW_W-1:0] out_y_next;
    logic [PIX_W-1:0] out_pixel_reg;
    logic [PIX_W-1:0] out_pixel_next;
    logic             last_reg;
    logic             last_next;
    logic             fe_reg;
    logic             fe_next;
    state_t           vert_done;

    sbl_alu u_alu (
        .clk (clk),
        .req (alu_req),
        .res (alu_res)
    );

    // entry c holds {row y-2, row y-1} of horizontally blurred pixels
    sbl_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (col_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // effective last column and last row
    always_comb
    begin
        if (fw_reg == '0)
        begin
            wm1 = '0;
        end
        else if (fw_reg > FW_W'(MAX_WIDTH))
        begin
            wm1 = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = COL_W'(fw_reg - 10'd1);
        end
        if (fh_reg == '0)
        begin
            hm1 = '0;
        end
        else if (fh_reg > FH_W'(MAX_HEIGHT))
        begin
            hm1 = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1 = ROW_W'(fh_reg - 9'd1);
        end
    end

    assign cur_row_end  = col_cnt_reg >= wm1;
    assign cur_last_row = row_cnt_reg >= hm1;
    assign in_stall     = state_reg != ST_IDLE;
    assign in_accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free     = !out_valid_reg || !out_stall;
    assign up2          = (y_reg == '0) ? hv_reg : m_reg;
    assign vert_done    = (!phase_b_reg && row_end_reg) ? ST_HTAP : ST_IDLE;

    always_comb
    begin
        case (step_reg)
            2'd0:    mul_byte = pix_reg[23:16];
            2'd1:    mul_byte = pix_reg[15:8];
            default: mul_byte = pix_reg[7:0];
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        alu_req.en     = 1'b0;
        alu_req.op     = ALU_MUL;
        alu_req.a      = '0;
        alu_req.b      = '0;
        alu_req.c      = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = x_reg;
        ram_wr_en      = 1'b0;
        ram_wr_data    = {ram_rd_data[PIX_W-1:0], alu_res};
        out_load       = 1'b0;
        out_x_next     = x_reg;
        out_y_next     = y_reg;
        out_pixel_next = alu_res;
        last_next      = 1'b1;
        fe_next        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (scan_reg && row_cnt_reg[0]) ? ST_LUM : ST_DISPATCH;
                end
            end
            ST_LUM:
            begin
                alu_req.en = 1'b1;
                alu_req.a  = {16'd0, scan_lum(pix_reg)};
                alu_req.b  = {16'd0, LUM_GAIN};
                state_next = ST_FAC;
            end
            ST_FAC:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (step_reg == 2'd3)
                begin
                    state_next = ST_DISPATCH;
                end
                else
                begin
                    alu_req.en = 1'b1;
                    alu_req.a  = {16'd0, mul_byte};
                    alu_req.b  = {16'd0, f_reg};
                end
            end
            ST_DISPATCH:
            begin
                if (!blur_item_reg)
                begin
                    state_next = ST_NEMIT;
                end
                else if (x_reg != '0 || row_end_reg)
                begin
                    state_next = ST_HTAP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_NEMIT:
            begin
                out_pixel_next = pix_reg;
                fe_next        = row_end_reg && last_row_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_HTAP:
            begin
                alu_req.en  = 1'b1;
                alu_req.op  = ALU_TAP;
                alu_req.a   = left_reg;
                alu_req.b   = center_reg;
                alu_req.c   = phase_b_reg ? center_reg : pix_reg;
                ram_rd_en   = 1'b1;
                ram_rd_addr = phase_b_reg ? x_reg : x_reg - 9'd1;
                state_next  = ST_VLOAD;
            end
            ST_VLOAD:
            begin
                ram_wr_en = 1'b1;
                if (y_reg == '0)
                begin
                    ram_wr_data = {alu_res, alu_res};
                end
                if (y_reg != '0 || last_row_reg)
                begin
                    state_next = ST_VTAP;
                end
                else
                begin
                    state_next = vert_done;
                end
            end
            ST_VTAP:
            begin
                alu_req.en = 1'b1;
                alu_req.op = ALU_TAP;
                alu_req.a  = vsel_reg ? up2 : u_reg;
                alu_req.b  = vsel_reg ? hv_reg : m_reg;
                alu_req.c  = hv_reg;
                state_next = ST_VEMIT;
            end
            ST_VEMIT:
            begin
                out_x_next = col_reg;
                out_y_next = vsel_reg ? y_reg : y_reg - 8'd1;
                fe_next    = vsel_reg && phase_b_reg;
                last_next  = !(!vsel_reg && last_row_reg) && !(!phase_b_reg && row_end_reg);
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = (!vsel_reg && last_row_reg) ? ST_VTAP : vert_done;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fw_reg        <= FW_RESET;
            fh_reg        <= FH_RESET;
            scan_reg      <= 1'b0;
            blur_reg      <= 1'b0;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            step_reg      <= '0;
            phase_b_reg   <= 1'b0;
            vsel_reg      <= 1'b0;
            left_reg      <= '0;
            center_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  fw_reg   <= cfg_data;
                    CFG_FRAME_HEIGHT: fh_reg   <= cfg_data[FH_W-1:0];
                    CFG_SCANLINE:     scan_reg <= cfg_data[0];
                    CFG_BLUR:         blur_reg <= cfg_data[0];
                    default:          fw_reg   <= fw_reg;
                endcase
            end

            if (in_accept)
            begin
                step_reg <= '0;
                if (cur_row_end)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= cur_last_row ? '0 : row_cnt_reg + 8'd1;
                end
                else
                begin
                    col_cnt_reg <= col_cnt_reg + 9'd1;
                end
            end

            if (state_reg == ST_MUL)
            begin
                step_reg <= step_reg + 2'd1;
            end

            // first pixel of a row replicates into both taps
            if (state_reg == ST_DISPATCH && blur_item_reg && x_reg == '0)
            begin
                left_reg   <= pix_reg;
                center_reg <= pix_reg;
            end

            if (state_reg == ST_HTAP && !phase_b_reg)
            begin
                left_reg   <= center_reg;
                center_reg <= pix_reg;
            end

            if (state_next == ST_HTAP)
            begin
                phase_b_reg <= (state_reg != ST_DISPATCH) || (x_reg == '0);
            end

            if (state_next == ST_VTAP)
            begin
                vsel_reg <= (state_reg == ST_VEMIT) || (y_reg == '0);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-pixel payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pix_reg       <= pixel;
            x_reg         <= col_cnt_reg;
            y_reg         <= row_cnt_reg;
            row_end_reg   <= cur_row_end;
            last_row_reg  <= cur_last_row;
            blur_item_reg <= blur_reg;
        end

        if (state_reg == ST_FAC)
        begin
            f_reg <= scan_factor(alu_res[13:0]);
        end

        // capture the channel issued in the previous cycle
        if (state_reg == ST_MUL)
        begin
            case (step_reg)
                2'd1:    pix_reg[23:16] <= alu_res[15:8];
                2'd2:    pix_reg[15:8]  <= alu_res[15:8];
                2'd3:    pix_reg[7:0]   <= alu_res[15:8];
                default: pix_reg        <= pix_reg;
            endcase
        end

        if (state_reg == ST_HTAP)
        begin
            col_reg <= ram_rd_addr;
        end

        if (state_reg == ST_VLOAD)
        begin
            u_reg  <= ram_rd_data[LINE_W-1:PIX_W];
            m_reg  <= ram_rd_data[PIX_W-1:0];
            hv_reg <= alu_res;
        end

        if (out_load)
        begin
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_pixel_reg <= out_pixel_next;
            last_reg      <= last_next;
            fe_reg        <= fe_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_pixel   = out_pixel_reg;
    assign last_of_run = last_reg;
    assign frame_end   = fe_reg;

endmodule

// ===== design/sbl_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbl_ram
// generic simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module sbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sbl_alu.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbl_alu
// shared unit: 8x8 multiply or per-channel 1-2-1 tap, registered result
// ---------------------------------------------------------------------------
module sbl_alu
    import sbl_pkg::*;
(
    input  logic             clk,
    input  alu_req_t         req,
    output logic [PIX_W-1:0] res
);

    logic [15:0]      mul_val;
    logic [PIX_W-1:0] tap_val;
    logic [9:0]       lane_sum;
    logic [PIX_W-1:0] res_reg;

    assign mul_val = {8'd0, req.a[7:0]} * {8'd0, req.b[7:0]};

    // three independent channel lanes
    always_comb
    begin
        tap_val  = '0;
        lane_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            lane_sum = {2'b00, req.a[8*i +: 8]} + {1'b0, req.b[8*i +: 8], 1'b0}
                     + {2'b00, req.c[8*i +: 8]};
            tap_val[8*i +: 8] = lane_sum[9:2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            case (req.op)
                ALU_MUL: res_reg <= {8'd0, mul_val};
                ALU_TAP: res_reg <= tap_val;
                default: res_reg <= '0;
            endcase
        end
    end

    assign res = res_reg;

endmodule

// ===== tb/sv/scanline_and_separable_blur_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scanline_and_separable_blur_tb
// self-checking bench for the scanline darkening and 3x3 binomial blur block
// ---------------------------------------------------------------------------
// pixels stream in raster order through a valid / stall channel. every
// accepted pixel runs through a behavioral model of the counts, the scanline
// scaling and the two blur passes, and the resulting beats are queued. a
// monitor compares each output beat field by field with the oldest queued
// one. directed tests hit reset geometry, clamped and shrunk frame sizes,
// channel extremes and blur edge replication; random frames follow under
// three idle patterns, then size extremes and a long output hold.
// ---------------------------------------------------------------------------
module scanline_and_separable_blur_tb
    import sbl_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic [PIX_W-1:0] rgb;
        logic             last;
        logic             fend;
    } pixel_result_t;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel       = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [COL_W-1:0]      out_x;
    logic [ROW_W-1:0]      out_y;
    logic [PIX_W-1:0]      out_pixel;
    logic                  last_of_run;
    logic                  frame_end;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // model state
    int unsigned      fw_reg    = FW_RESET;
    int unsigned      fh_reg    = FH_RESET;
    bit               scan_on   = 1'b0;
    bit               blur_on   = 1'b0;
    int unsigned      col_cnt   = 0;
    int unsigned      row_cnt   = 0;
    logic [PIX_W-1:0] left_px   = '0;
    logic [PIX_W-1:0] center_px = '0;
    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    pixel_result_t    run_buf    [4];
    int               run_n;

    pixel_result_t    expected_q[$];
    pixel_result_t    head;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int error_count    = 0;
    int pixels_sent    = 0;
    int results_seen   = 0;

    scanline_and_separable_blur DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_pixel   (out_pixel),
        .last_of_run (last_of_run),
        .frame_end   (frame_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // behavioral model
    // ------------------------------------------------------------------
    function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
        if (v < 1)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] darken_px(logic [PIX_W-1:0] p);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned lum;
        int unsigned f;
        r = 32'(p[23:16]);
        g = 32'(p[15:8]);
        b = 32'(p[7:0]);
        lum = (r >> 2) + (g >> 1) + (g >> 3) + (b >> 3);
        f = 32'(SCAN_BASE) + lum * 32'(LUM_GAIN) / 255;
        r = (r * f) >> 8;
        g = (g * f) >> 8;
        b = (b * f) >> 8;
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    // [1 2 1]/4 per channel, truncating
    function automatic logic [PIX_W-1:0] binomial3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] c,
                                                   logic [PIX_W-1:0] e);
        logic [PIX_W-1:0] res;
        logic [9:0]       s;
        for (int k = 0; k < 3; k++)
        begin
            s = {2'b00, a[8*k +: 8]} + {1'b0, c[8*k +: 8], 1'b0} + {2'b00, e[8*k +: 8]};
            res[8*k +: 8] = s[9:2];
        end
        return res;
    endfunction

    function automatic void push_result(int unsigned x, int unsigned y, logic [PIX_W-1:0] p,
                                        bit fend);
        run_buf[run_n].x    = x[COL_W-1:0];
        run_buf[run_n].y    = y[ROW_W-1:0];
        run_buf[run_n].rgb  = p;
        run_buf[run_n].last = 1'b0;
        run_buf[run_n].fend = fend;
        run_n++;
    endfunction

    // vertical pass for one column; row 0 primes the line stores, emitting only on a last row
    function automatic void vertical_pass(int unsigned c, int unsigned y, logic [PIX_W-1:0] hv,
                                          bit last_row, bit end_col);
        if (y == 0)
        begin
            upper_mem[c]  = hv;
            middle_mem[c] = hv;
        end
        else
        begin
            push_result(c, y - 1, binomial3(upper_mem[c], middle_mem[c], hv), 1'b0);
            upper_mem[c]  = middle_mem[c];
            middle_mem[c] = hv;
        end
        // bottom edge replicates the last row
        if (last_row)
            push_result(c, y, binomial3(upper_mem[c], middle_mem[c], middle_mem[c]), end_col);
    endfunction

    function automatic void predict_pixel(logic [PIX_W-1:0] pin);
        int unsigned      w;
        int unsigned      h;
        int unsigned      x;
        int unsigned      y;
        logic [PIX_W-1:0] p;
        logic [PIX_W-1:0] hv;
        bit               row_end;
        bit               last_row;
        w = clamp_dim(fw_reg, MAX_WIDTH);
        h = clamp_dim(fh_reg, MAX_HEIGHT);
        x = col_cnt;
        y = row_cnt;
        p = pin;
        row_end  = (x >= w - 1);
        last_row = (y >= h - 1);
        run_n = 0;
        if (scan_on && y[0])
            p = darken_px(p);
        if (!blur_on)
            push_result(x, y, p, row_end && last_row);
        else
        begin
            if (x == 0)
            begin
                left_px   = p;
                center_px = p;
            end
            else
            begin
                hv = binomial3(left_px, center_px, p);
                vertical_pass(x - 1, y, hv, last_row, 1'b0);
                left_px   = center_px;
                center_px = p;
            end
            // right edge replicates the last column
            if (row_end)
            begin
                hv = binomial3(left_px, center_px, center_px);
                vertical_pass(x, y, hv, last_row, 1'b1);
            end
        end
        if (run_n > 0)
            run_buf[run_n - 1].last = 1'b1;
        for (int i = 0; i < run_n; i++)
            expected_q.push_back(run_buf[i]);
        if (row_end)
        begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : y + 1;
        end
        else
            col_cnt = x + 1;
    endfunction

    // ------------------------------------------------------------------
    // receiver, monitor and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none actual x=%0d y=%0d pixel=%h",
                         $time, out_x, out_y, out_pixel);
                error_count++;
            end
            else
            begin
                head = expected_q.pop_front();
                check_field("out_x", 32'(head.x), 32'(out_x));
                check_field("out_y", 32'(head.y), 32'(out_y));
                check_field("out_pixel", 32'(head.rgb), 32'(out_pixel));
                check_field("last_of_run", 32'(head.last), 32'(last_of_run));
                check_field("frame_end", 32'(head.fend), 32'(frame_end));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no beat accepted for %0d cycles, %0d results pending",
                     $time, idle_cycles, expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(logic [PIX_W-1:0] p);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        do
            @(posedge clk);
        while (in_stall);
        predict_pixel(p);
        pixels_sent++;
    endtask

    // a pixel with no result may still be in work, so settle after the last beat
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  fw_reg  = 32'(value[FW_W-1:0]);
            CFG_FRAME_HEIGHT: fh_reg  = 32'(value[FH_W-1:0]);
            CFG_SCANLINE:     scan_on = value[0];
            CFG_BLUR:         blur_on = value[0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(int unsigned width, int unsigned height, bit scan, bit blur);
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, width);
        write_reg(CFG_FRAME_HEIGHT, height);
        write_reg(CFG_SCANLINE, 32'(scan));
        write_reg(CFG_BLUR, 32'(blur));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // 320 x 224 out of reset, then sizes of zero clamp to one mid-row
    task automatic test_reset_geometry();
        send_pixel('0);
        send_pixel('1);
        send_pixel(24'h800000);
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 0);
        write_reg(CFG_FRAME_HEIGHT, 0);
        send_pixel(PIX_W'($urandom));
        send_pixel(PIX_W'($urandom));
    endtask

    task automatic test_scanline_darkening();
        configure(3, 2, 1'b1, 1'b0);
        send_pixel(24'hFF0000);
        send_pixel(24'h0000FF);
        send_pixel(PIX_W'($urandom));
        send_pixel('1);
        send_pixel('0);
        send_pixel(24'h00FF00);
    endtask

    task automatic test_blur_edges();
        configure(3, 3, 1'b1, 1'b1);
        send_pixel('1);
        send_pixel('0);
        send_pixel('1);
        send_pixel('0);
        send_pixel('1);
        send_pixel('0);
        repeat (3) send_pixel(PIX_W'($urandom));
        configure(1, 1, 1'b0, 1'b1);
        send_pixel(PIX_W'($urandom));
    endtask

    // width and height lowered below the current counts in the middle of row 1
    task automatic test_mid_frame_shrink();
        configure(4, 4, 1'b0, 1'b1);
        repeat (6) send_pixel(pick_pixel());
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 2);
        write_reg(CFG_FRAME_HEIGHT, 1);
        send_pixel(pick_pixel());
    endtask

    // register values above the maximum run past small counts, then a size
    // of zero closes the row or the frame early
    task automatic test_size_extremes();
        configure(1023, 1, 1'b0, 1'b1);
        repeat (6) send_pixel(pick_pixel());
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 0);
        send_pixel(pick_pixel());
        configure(1, 511, 1'b1, 1'b1);
        repeat (6) send_pixel(pick_pixel());
        wait_drained();
        write_reg(CFG_FRAME_HEIGHT, 0);
        send_pixel(pick_pixel());
    endtask

    task automatic test_random_frames(int count);
        int          first;
        int unsigned eff_w;
        first = pixels_sent;
        while (pixels_sent - first < count)
        begin
            configure(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8),
                      $urandom_range(0, 5), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            do
            begin
                send_pixel(pick_pixel());
                // occasional mid-frame change; width only ever shrinks so the
                // line stores are never read ahead of row 0
                if ((col_cnt != 0 || row_cnt != 0) && $urandom_range(0, 24) == 0)
                begin
                    wait_drained();
                    eff_w = clamp_dim(fw_reg, MAX_WIDTH);
                    case ($urandom_range(0, 2))
                        0: write_reg(CFG_SCANLINE, 32'(!scan_on));
                        1: if (eff_w > 1)
                               write_reg(CFG_FRAME_WIDTH, $urandom_range(0, eff_w - 1));
                        default: write_reg(CFG_FRAME_HEIGHT, $urandom_range(0, 5));
                    endcase
                end
            end
            while (col_cnt != 0 || row_cnt != 0);
        end
    endtask

    task automatic test_output_hold();
        configure(4, 3, 1'b1, 1'b1);
        hold_requests++;
        repeat (12) send_pixel(pick_pixel());
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 25;
        recv_stall_pct = 72;
        test_reset_geometry();
        test_scanline_darkening();
        test_blur_edges();
        test_mid_frame_shrink();
        test_random_frames(25);

        send_idle_pct  = 72;
        recv_stall_pct = 25;
        test_random_frames(25);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_frames(25);
        test_size_extremes();
        test_output_hold();

        wait_drained();
        $display("covered %0d pixels and %0d result beats: small and clamped frame sizes,",
                 pixels_sent, results_seen);
        $display("scanlines and blur in all mixes, mid-frame shrinks, output hold");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
